/* design/printer_option_parse_record_framer_unit_defines.svh */
// Assertion macros shared by the printer option parser and record framer.
// Used by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef PRINTER_OPTION_PARSE_RECORD_FRAMER_UNIT_DEFINES_SVH
`define PRINTER_OPTION_PARSE_RECORD_FRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define POFR_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define POFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define POFR_ASSERT(label, expr, msg)
`define POFR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/pofr_pkg.sv */
// Types, codes and option tables for the printer option parser and record framer.
// No dependencies; imported by every module of the block.
package pofr_pkg;

  typedef enum logic [2:0] {
    ACT_NAME_START = 3'd0,
    ACT_NAME_CHAR  = 3'd1,
    ACT_NAME_END   = 3'd2,
    ACT_REC_START  = 3'd3,
    ACT_REC_BYTE   = 3'd4,
    ACT_REC_END    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_BYTE,
    CMD_TRAILER
  } cmd_op_t;

  localparam int NFLAGS       = 5;
  localparam int FLAG_PARITY  = 0;
  localparam int FLAG_NO_CRLF = 1;
  localparam int FLAG_NO_LF   = 2;
  localparam int FLAG_NULL_PAD = 3;
  localparam int FLAG_ECHO_OFF = 4;

  localparam int NOPTS    = 11;
  localparam int POS_W    = 3;
  localparam int OPT_SLOTS = 8;
  localparam logic [NOPTS-1:0] ALL_OPTS = '1;

  localparam int PAD_CAP               = 6;
  localparam int NUL_PAD_COUNT_DEFAULT = 6;
  localparam int QUEUE_DEPTH_DEFAULT   = 4;
  localparam int STEP_W  = $clog2(PAD_CAP + 2);
  localparam int COUNT_W = $clog2(PAD_CAP + 3);

  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic RESULT_KIND_BYTE   = 1'b0;
  localparam logic RESULT_KIND_STATUS = 1'b1;

  localparam logic [7:0] OPT_TEXT [0:NOPTS-1][0:OPT_SLOTS-1] = '{
    '{".", "B", "A", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", "D", "A", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", "T", "W", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", "C", "H", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", "P", "A", "=",   "N",   8'h00, 8'h00, 8'h00},
    '{".", "P", "A", "=",   "E",   8'h00, 8'h00, 8'h00},
    '{".", "P", "A", "=",   "O",   8'h00, 8'h00, 8'h00},
    '{".", "C", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", "L", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", "N", "U", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{".", "E", "C", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [POS_W-1:0] OPT_LEN [0:NOPTS-1] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3
  };

  localparam logic [NFLAGS-1:0] OPT_BIT [0:NOPTS-1] = '{
    5'h00, 5'h00, 5'h00, 5'h01, 5'h00, 5'h00, 5'h00, 5'h02, 5'h04, 5'h08, 5'h10
  };

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_in;
    logic       internal_format;
    logic       variable_format;
    logic [7:0] record_length;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    logic       bad_mode;
    logic       parity_flag;
    logic       no_crlf;
    logic       no_lf;
    logic       null_pad;
    logic       echo_off;
    logic       last;
  } rsp_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [7:0]        data;
    logic              bad;
    logic [NFLAGS-1:0] flags;
  } cmd_t;

endpackage

/* design/pofr_front.sv */
// Front end: accepts items, runs the option matcher, and issues output commands.
// Depends on pofr_pkg and the assertion macro header.
`include "printer_option_parse_record_framer_unit_defines.svh"

module pofr_front
  import pofr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t request,
  input  logic q_full,
  output logic cmd_push,
  output cmd_t cmd
);

  logic              matching, matching_next;
  logic [POS_W-1:0]  match_position, match_position_next;
  logic [NOPTS-1:0]  candidate_mask, candidate_mask_next;
  logic [NFLAGS-1:0] option_flags, option_flags_next;
  logic              parse_error, parse_error_next;
  logic              record_internal, record_internal_next;
  logic              record_variable, record_variable_next;

  logic              accept;
  logic [7:0]        c_up;
  logic [NOPTS-1:0]  keep;
  logic              hit;
  logic [NFLAGS-1:0] set_bits;
  cmd_op_t           cmd_op;
  logic [7:0]        cmd_data;

  assign accept = push && !q_full;

  always_comb begin
    if (request.char_in inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      c_up = request.char_in - CASE_OFFSET;
    end else begin
      c_up = request.char_in;
    end
    keep     = '0;
    hit      = 1'b0;
    set_bits = '0;
    for (int i = 0; i < NOPTS; i++) begin
      keep[i] = candidate_mask[i] && (match_position < OPT_LEN[i]) &&
                (OPT_TEXT[i][match_position] == c_up);
      if (keep[i] && (OPT_LEN[i] == match_position + 3'd1)) begin
        hit      = 1'b1;
        set_bits = set_bits | OPT_BIT[i];
      end
    end
  end

  always_comb begin
    matching_next        = matching;
    match_position_next  = match_position;
    candidate_mask_next  = candidate_mask;
    option_flags_next    = option_flags;
    parse_error_next     = parse_error;
    record_internal_next = record_internal;
    record_variable_next = record_variable;
    cmd_push             = 1'b0;
    cmd_op               = CMD_BYTE;
    cmd_data             = request.char_in;
    if (accept) begin
      case (action_t'(request.action))
        ACT_NAME_START: begin
          matching_next       = 1'b0;
          match_position_next = '0;
          candidate_mask_next = '0;
          option_flags_next   = '0;
          parse_error_next    = 1'b0;
        end
        ACT_NAME_CHAR: begin
          if (!parse_error) begin
            if (!matching) begin
              if (request.char_in == CHAR_DOT) begin
                matching_next       = 1'b1;
                match_position_next = 3'd1;
                candidate_mask_next = ALL_OPTS;
              end
            end else if (hit) begin
              option_flags_next   = option_flags | set_bits;
              matching_next       = 1'b0;
              match_position_next = '0;
              candidate_mask_next = '0;
            end else if (keep == '0) begin
              parse_error_next    = 1'b1;
              matching_next       = 1'b0;
              match_position_next = '0;
              candidate_mask_next = '0;
            end else begin
              candidate_mask_next = keep;
              match_position_next = match_position + 3'd1;
            end
          end
        end
        ACT_NAME_END: begin
          if (matching) begin
            parse_error_next    = 1'b1;
            matching_next       = 1'b0;
            match_position_next = '0;
            candidate_mask_next = '0;
          end
          cmd_push = 1'b1;
          cmd_op   = CMD_STATUS;
          cmd_data = CHAR_NUL;
        end
        ACT_REC_START: begin
          record_internal_next = request.internal_format;
          record_variable_next = request.variable_format;
          if (!parse_error && request.internal_format) begin
            cmd_push = 1'b1;
            cmd_data = request.record_length;
          end
        end
        ACT_REC_BYTE: begin
          cmd_push = !parse_error;
        end
        ACT_REC_END: begin
          if (!parse_error && record_variable && !record_internal &&
              (!option_flags[FLAG_NO_CRLF] || option_flags[FLAG_NULL_PAD] ||
               !option_flags[FLAG_NO_LF])) begin
            cmd_push = 1'b1;
            cmd_op   = CMD_TRAILER;
          end
        end
        default: begin
        end
      endcase
    end
    cmd.op    = cmd_op;
    cmd.data  = cmd_data;
    cmd.bad   = parse_error_next;
    cmd.flags = option_flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matching        <= 1'b0;
      match_position  <= '0;
      candidate_mask  <= '0;
      option_flags    <= '0;
      parse_error     <= 1'b0;
      record_internal <= 1'b0;
      record_variable <= 1'b0;
    end else begin
      matching        <= matching_next;
      match_position  <= match_position_next;
      candidate_mask  <= candidate_mask_next;
      option_flags    <= option_flags_next;
      parse_error     <= parse_error_next;
      record_internal <= record_internal_next;
      record_variable <= record_variable_next;
    end
  end

  `POFR_ASSERT(a_match_has_candidates, !matching || (candidate_mask != '0 && match_position != '0), "open match without candidates")
  `POFR_ASSERT(a_idle_match_clear, matching || (candidate_mask == '0 && match_position == '0), "stale match state while idle")
  `POFR_ASSERT(a_error_stops_match, !parse_error || !matching, "match open with error set")

endmodule

/* design/pofr_queue.sv */
// Command queue between the front end and the output sequencer.
// Depends on pofr_pkg and the assertion macro header.
`include "printer_option_parse_record_framer_unit_defines.svh"

module pofr_queue
  import pofr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CNT_MAX);
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `POFR_ASSERT(a_no_write_when_full, !(wr_en && full), "write into full queue")
  `POFR_ASSERT(a_no_read_when_empty, !(rd_en && empty), "read from empty queue")
  `POFR_ASSERT(a_count_bound, count <= CNT_MAX, "queue count out of range")
  `POFR_ASSERT_NEXT(a_count_grows, wr_en && !rd_en, count == $past(count) + 1'b1, "count missed a write")

endmodule

/* design/pofr_back.sv */
// Output sequencer: expands queued commands into result items, trailers included.
// Depends on pofr_pkg; holds the registered result stage.
module pofr_back
  import pofr_pkg::*;
#(
  parameter int NUL_PAD_COUNT = NUL_PAD_COUNT_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output rsp_t result
);

  localparam int PAD_LEN = (NUL_PAD_COUNT > PAD_CAP) ? PAD_CAP : NUL_PAD_COUNT;

  logic [STEP_W-1:0]  step;
  logic               out_valid;
  logic               has_cr;
  logic               has_lf;
  logic [COUNT_W-1:0] pad_n;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] rel;
  logic [7:0]         tr_byte;
  logic               is_last;
  logic               take;
  logic               load;
  rsp_t               res_next;

  always_comb begin
    has_cr  = !cmd.flags[FLAG_NO_CRLF];
    has_lf  = !cmd.flags[FLAG_NO_LF];
    pad_n   = cmd.flags[FLAG_NULL_PAD] ? COUNT_W'(PAD_LEN) : '0;
    total   = COUNT_W'(has_cr) + pad_n + COUNT_W'(has_lf);
    rel     = COUNT_W'(step) - COUNT_W'(has_cr);
    if (has_cr && step == '0) begin
      tr_byte = CHAR_CR;
    end else if (rel < pad_n) begin
      tr_byte = CHAR_NUL;
    end else begin
      tr_byte = CHAR_LF;
    end

    res_next.result_kind = RESULT_KIND_BYTE;
    res_next.out_byte    = cmd.data;
    res_next.bad_mode    = cmd.bad;
    res_next.parity_flag = cmd.flags[FLAG_PARITY];
    res_next.no_crlf     = cmd.flags[FLAG_NO_CRLF];
    res_next.no_lf       = cmd.flags[FLAG_NO_LF];
    res_next.null_pad    = cmd.flags[FLAG_NULL_PAD];
    res_next.echo_off    = cmd.flags[FLAG_ECHO_OFF];
    is_last              = 1'b1;
    case (cmd.op)
      CMD_STATUS: begin
        res_next.result_kind = RESULT_KIND_STATUS;
        res_next.out_byte    = CHAR_NUL;
      end
      CMD_TRAILER: begin
        res_next.out_byte = tr_byte;
        is_last           = (COUNT_W'(step) + COUNT_W'(1) == total);
      end
      default: begin
      end
    endcase
    res_next.last = is_last;
  end

  assign take    = pop && out_valid;
  assign load    = cmd_valid && (!out_valid || take);
  assign cmd_pop = load && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= is_last ? '0 : step + 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule

/* design/printer_option_parse_record_framer_unit.sv */
// Top level of the printer option parser and record framer.
// Instantiates pofr_front, pofr_queue and pofr_back; depends on pofr_pkg.
//
// Accepts one item per cycle while full is low. Name items update the option
// matcher in the cycle they are accepted; items that produce output post one
// command to a QUEUE_DEPTH-entry queue, and the output sequencer turns each
// command into results, one per cycle while pop is high, from a registered
// output stage. A record end on a variable record expands to up to
// 2 + min(NUL_PAD_COUNT, 6) results in the sequencer, so full rises only when
// trailers arrive faster than they drain or pop is held low. The first result
// of an item is written to the queue and then loaded into the output stage.
module printer_option_parse_record_framer_unit
  import pofr_pkg::*;
#(
  parameter int NUL_PAD_COUNT = NUL_PAD_COUNT_DEFAULT,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic empty,
  input  logic pop,
  output rsp_t result
);

  logic cmd_push;
  cmd_t cmd_in;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  assign full = q_full;

  pofr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  pofr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  pofr_back #(
    .NUL_PAD_COUNT (NUL_PAD_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
